// ===== sv/dcf_pkg.sv =====
// ---------------------------------------------------------------------------
// dcf_pkg
// Shared types, constants and BCD helper for the DCF77 time code receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

    localparam int FRAME_BITS = 59;
    localparam int FRAME_W    = FRAME_BITS + 1;
    localparam int CNT_W      = 6;
    localparam int CFG_W      = 16;

    localparam logic [CNT_W-1:0] SEC_WRAP    = 6'd60;
    localparam logic [7:0]       MIN_WRAP    = 8'd60;
    localparam logic [7:0]       HOUR_WRAP   = 8'd24;
    localparam logic [CNT_W-1:0] FRAME_LEN   = 6'd59;
    localparam logic [CNT_W-1:0] FRAME_OVER  = 6'd60;
    localparam logic [11:0]      YEAR_BASE   = 12'd2000;

    localparam logic [CFG_W-1:0] SYNC_GAP_RESET = 16'd1200;
    localparam logic [CFG_W-1:0] SPLIT_RESET    = 16'd140;

    typedef enum logic [0:0] {
        CFG_SYNC_GAP = 1'b0,
        CFG_SPLIT    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [5:0]  day;
        logic [4:0]  month;
        logic [11:0] year;
    } date_t;

    typedef struct packed {
        logic        level_echo;
        logic [5:0]  seconds;
        logic [7:0]  minutes;
        logic [7:0]  hours;
        logic [5:0]  day_of_month;
        logic [4:0]  month_number;
        logic [11:0] year_number;
        logic        frame_decoded;
    } result_t;

    // v - (v / 16) * 6, digits not checked
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        logic [7:0] tens;
        tens = {4'b0, v[7:4]};
        return v - 8'(tens * 8'd6);
    endfunction

endpackage

`default_nettype wire

// ===== sv/dcf_frame_decode.sv =====
// ---------------------------------------------------------------------------
// dcf_frame_decode
// Pulls the BCD date and time fields out of a received frame and converts them.
// ---------------------------------------------------------------------------
`default_nettype none

module dcf_frame_decode (
    input  wire logic [dcf_pkg::FRAME_W-1:0] frame_bits,
    output dcf_pkg::date_t                   date
);
    import dcf_pkg::*;

    logic [7:0] year_bcd;

    assign year_bcd = bcd_value(frame_bits[57:50]);

    always_comb
    begin
        date.minute = bcd_value({1'b0, frame_bits[27:21]});
        date.hour   = bcd_value({2'b0, frame_bits[34:29]});
        date.day    = 6'(bcd_value({2'b0, frame_bits[41:36]}));
        date.month  = 5'(bcd_value({3'b0, frame_bits[49:45]}));
        date.year   = YEAR_BASE + {4'b0, year_bcd};
    end

endmodule

`default_nettype wire

// ===== sv/dcf77_time_code_receiver.sv =====
// ---------------------------------------------------------------------------
// dcf77_time_code_receiver
// Edge detection, pulse timing, running clock and frame decode for DCF77.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  : one receiver level sample with its millisecond timestamp per
//                 transfer (in_valid / in_stall).
//   out channel : one result per input transfer (out_valid / out_stall):
//                 running time, last decoded date, frame_decoded flag.
//   cfg channel : cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
//                 the sync gap, index 1 the bit split threshold. Always ready.
//   The result of a transfer is registered in the output register, or in the
//   skid register while the output is held. Throughput is one item per cycle
//   while in_stall is low, set by the single state update at each input transfer.
//   When the receiver stalls, the output register holds its result and one
//   more result is caught in a skid register; in_stall rises only once the
//   skid register is full.
//   Reset clears the clock, frame, date and edge state and loads the default
//   thresholds (1200 ms and 140 ms); no result is pending after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module dcf77_time_code_receiver #(
    parameter int TIME_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        level,
    input  wire logic [31:0] now_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             level_echo,
    output logic [5:0]       seconds,
    output logic [7:0]       minutes,
    output logic [7:0]       hours,
    output logic [5:0]       day_of_month,
    output logic [4:0]       month_number,
    output logic [11:0]      year_number,
    output logic             frame_decoded,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire dcf_pkg::cfg_index_t cfg_index,
    input  wire logic [15:0] cfg_data
);
    import dcf_pkg::*;

    logic [CFG_W-1:0]     sync_gap_reg;
    logic [CFG_W-1:0]     split_reg;

    logic                 last_level_reg, last_level_next;
    logic [TIME_BITS-1:0] last_rise_reg, last_rise_next;
    logic [CNT_W-1:0]     bit_count_reg, bit_count_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [5:0]           sec_reg, sec_next;
    logic [7:0]           min_reg, min_next;
    logic [7:0]           hour_reg, hour_next;
    logic [5:0]           day_reg, day_next;
    logic [4:0]           month_reg, month_next;
    logic [11:0]          year_reg, year_next;

    result_t              out_reg, out_next;
    result_t              skid_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;

    result_t              result;
    date_t                date;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] diff;
    logic                 decoded;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 data_bit;
    logic [CNT_W-1:0]     count_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_xfer   = in_valid && !skid_valid_reg;
    assign out_xfer  = out_valid_reg && !out_stall;

    assign now_t     = now_ms[TIME_BITS-1:0];
    assign diff      = now_t - last_rise_reg;
    assign data_bit  = (diff >= TIME_BITS'(split_reg));
    assign count_inc = bit_count_reg + 6'd1;

    dcf_frame_decode u_decode (
        .frame_bits (frame_reg),
        .date       (date)
    );

    // one sample step
    always_comb
    begin
        last_level_next = last_level_reg;
        last_rise_next  = last_rise_reg;
        bit_count_next  = bit_count_reg;
        frame_next      = frame_reg;
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        day_next        = day_reg;
        month_next      = month_reg;
        year_next       = year_reg;
        decoded         = 1'b0;

        if (level != last_level_reg)
        begin
            last_level_next = level;
            if (level)
            begin
                // rising edge: advance the running clock
                sec_next = sec_reg + 6'd1;
                if (sec_next == SEC_WRAP)
                begin
                    sec_next = '0;
                    min_next = min_reg + 8'd1;
                    if (min_next == MIN_WRAP)
                    begin
                        min_next  = '0;
                        hour_next = hour_reg + 8'd1;
                        if (hour_next == HOUR_WRAP)
                        begin
                            hour_next = '0;
                        end
                    end
                end
                if (diff > TIME_BITS'(sync_gap_reg))
                begin
                    if (bit_count_reg == FRAME_LEN)
                    begin
                        decoded    = 1'b1;
                        min_next   = date.minute;
                        hour_next  = date.hour;
                        day_next   = date.day;
                        month_next = date.month;
                        year_next  = date.year;
                    end
                    sec_next       = '0;
                    bit_count_next = '0;
                    frame_next     = '0;
                end
                last_rise_next = now_t;
            end
            else
            begin
                // falling edge: shift in one bit
                frame_next     = frame_reg | (FRAME_W'(data_bit) << bit_count_reg);
                bit_count_next = count_inc;
                if (count_inc == FRAME_OVER)
                begin
                    sec_next       = '0;
                    bit_count_next = '0;
                    frame_next     = '0;
                end
            end
        end
    end

    always_comb
    begin
        result.level_echo    = level;
        result.seconds       = sec_next;
        result.minutes       = min_next;
        result.hours         = hour_next;
        result.day_of_month  = day_next;
        result.month_number  = month_next;
        result.year_number   = year_next;
        result.frame_decoded = decoded;
    end

    // output register with one skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_xfer)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = in_xfer;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_gap_reg <= SYNC_GAP_RESET;
            split_reg    <= SPLIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SYNC_GAP: sync_gap_reg <= cfg_data;
                CFG_SPLIT:    split_reg    <= cfg_data;
                default:      sync_gap_reg <= sync_gap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b0;
            last_rise_reg  <= '0;
            bit_count_reg  <= '0;
            frame_reg      <= '0;
            sec_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
            day_reg        <= '0;
            month_reg      <= '0;
            year_reg       <= '0;
        end
        else if (in_xfer)
        begin
            last_level_reg <= last_level_next;
            last_rise_reg  <= last_rise_next;
            bit_count_reg  <= bit_count_next;
            frame_reg      <= frame_next;
            sec_reg        <= sec_next;
            min_reg        <= min_next;
            hour_reg       <= hour_next;
            day_reg        <= day_next;
            month_reg      <= month_next;
            year_reg       <= year_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (in_xfer && !skid_valid_reg && out_valid_reg && !out_xfer)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign level_echo    = out_reg.level_echo;
    assign seconds       = out_reg.seconds;
    assign minutes       = out_reg.minutes;
    assign hours         = out_reg.hours;
    assign day_of_month  = out_reg.day_of_month;
    assign month_number  = out_reg.month_number;
    assign year_number   = out_reg.year_number;
    assign frame_decoded = out_reg.frame_decoded;

endmodule

`default_nettype wire

// ===== sv/dcf_checker.sv =====
// ---------------------------------------------------------------------------
// dcf_checker
// Port-level checks for the DCF77 time code receiver, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module dcf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [5:0]  seconds,
    input wire logic [11:0] year_number,
    input wire logic        frame_decoded
);

    // running seconds never reach a full minute
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seconds < 6'd60)
        else $error("seconds out of range");

    // a decoded frame restarts the minute
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_decoded |-> seconds == 6'd0)
        else $error("decoded frame without seconds cleared");

    // a decoded year always carries the century offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_decoded |-> year_number >= 12'd2000)
        else $error("decoded year below base");

    // input backpressure only appears while the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && $past(out_valid && out_stall))
        else $error("input stalled without held output");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(seconds))
        else $error("stalled result changed");

endmodule

bind dcf77_time_code_receiver dcf_checker u_dcf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .seconds       (seconds),
    .year_number   (year_number),
    .frame_decoded (frame_decoded)
);

`default_nettype wire

// ===== verif/tb_dcf77_time_code_receiver.sv =====
// ---------------------------------------------------------------------------
// tb_dcf77_time_code_receiver
// Self-checking testbench for the DCF77 time code receiver. Level samples
// are sent as pulse trains shaped like real minute frames (sync gap, 59 bits,
// BCD date) plus broken frames, free-running pulses and random noise. A local
// model of the decoder predicts every result, and each output transfer is
// compared field by field. Thresholds are changed between phases, and both
// channels idle and stall in several patterns, including one long hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_dcf77_time_code_receiver;

    import dcf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        level = 1'b0;
    logic [31:0] now_ms = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        level_echo;
    logic [5:0]  seconds;
    logic [7:0]  minutes;
    logic [7:0]  hours;
    logic [5:0]  day_of_month;
    logic [4:0]  month_number;
    logic [11:0] year_number;
    logic        frame_decoded;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_SYNC_GAP;
    logic [15:0] cfg_data = 16'd0;

    dcf77_time_code_receiver uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .level         (level),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .level_echo    (level_echo),
        .seconds       (seconds),
        .minutes       (minutes),
        .hours         (hours),
        .day_of_month  (day_of_month),
        .month_number  (month_number),
        .year_number   (year_number),
        .frame_decoded (frame_decoded),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // decoder model state
    logic        prev_level = 1'b0;
    logic [31:0] rise_stamp = 32'd0;
    logic [5:0]  frame_len = 6'd0;
    logic [59:0] frame_reg = 60'd0;
    logic [5:0]  clk_sec = 6'd0;
    logic [7:0]  clk_min = 8'd0;
    logic [7:0]  clk_hour = 8'd0;
    logic [5:0]  date_day = 6'd0;
    logic [4:0]  date_month = 5'd0;
    logic [11:0] date_year = 12'd0;
    logic [15:0] gap_limit = SYNC_GAP_RESET;
    logic [15:0] split_limit = SPLIT_RESET;

    result_t expected_results[$];

    int mismatch_count = 0;
    int results_checked = 0;
    int samples_sent = 0;
    int frames_decoded = 0;
    int register_writes = 0;
    int input_stall_cycles = 0;

    int sender_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    logic    out_seen = 1'b0;
    result_t out_snap;
    result_t want;

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] tens;
        tens = {4'd0, v[7:4]};
        return tens * 8'd10 + {4'd0, v[3:0]};
    endfunction

    function automatic logic [7:0] bcd8(input int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    task automatic close_frame(output logic decoded);
        decoded = 1'b0;
        if (frame_len == FRAME_LEN)
        begin
            clk_min    = bcd_to_bin({1'b0, frame_reg[27:21]});
            clk_hour   = bcd_to_bin({2'b0, frame_reg[34:29]});
            date_day   = 6'(bcd_to_bin({2'b0, frame_reg[41:36]}));
            date_month = 5'(bcd_to_bin({3'b0, frame_reg[49:45]}));
            date_year  = 12'd2000 + {4'd0, bcd_to_bin(frame_reg[57:50])};
            decoded = 1'b1;
        end
        clk_sec   = 6'd0;
        frame_len = 6'd0;
        frame_reg = 60'd0;
    endtask

    task automatic shift_in(input logic b);
        logic dropped;
        if (frame_len < FRAME_OVER)
            frame_reg[frame_len] = b;
        frame_len = frame_len + 6'd1;
        if (frame_len >= FRAME_OVER)
            close_frame(dropped);
    endtask

    task automatic advance_second();
        clk_sec = clk_sec + 6'd1;
        if (clk_sec == SEC_WRAP)
        begin
            clk_sec = 6'd0;
            clk_min = clk_min + 8'd1;
            if (clk_min == MIN_WRAP)
            begin
                clk_min = 8'd0;
                clk_hour = clk_hour + 8'd1;
                if (clk_hour == HOUR_WRAP)
                    clk_hour = 8'd0;
            end
        end
    endtask

    task automatic predict_sample(input logic lv, input logic [31:0] stamp);
        logic [31:0] since_rise;
        logic        got_frame;
        got_frame = 1'b0;
        if (lv != prev_level)
        begin
            since_rise = stamp - rise_stamp;
            if (lv)
            begin
                advance_second();
                if (since_rise > {16'd0, gap_limit})
                    close_frame(got_frame);
                rise_stamp = stamp;
            end
            else
            begin
                shift_in(since_rise >= {16'd0, split_limit});
            end
            prev_level = lv;
        end
        if (got_frame)
            frames_decoded++;
        expected_results.push_back('{lv, clk_sec, clk_min, clk_hour, date_day,
                                     date_month, date_year, got_frame});
    endtask

    task automatic send_sample(input logic lv, input logic [31:0] stamp);
        logic stalled;
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        level    <= lv;
        now_ms   <= stamp;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            if (stalled)
                input_stall_cycles++;
            @(posedge clk);
        end
        while (stalled);
        predict_sample(lv, stamp);
        samples_sent++;
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [15:0] value);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end
        while (!rdy);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SYNC_GAP: gap_limit = value;
            CFG_SPLIT:    split_limit = value;
            default:      ;
        endcase
        register_writes++;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [15:0] gap, input logic [15:0] split);
        drain_block();
        write_register(CFG_SYNC_GAP, gap);
        write_register(CFG_SPLIT, split);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct = sender_pct;
        stall_pct = receiver_pct;
    endtask

    function automatic logic [31:0] pulse_width(input logic b);
        if (b)
            return {16'd0, split_limit} + $urandom_range(0, 300);
        else if (split_limit == 16'd0)
            return 32'd0;
        else
            return $urandom_range(0, split_limit - 1);
    endfunction

    // unchanged level at a random stamp, now and then
    task automatic maybe_noise();
        if ($urandom_range(0, 99) < 8)
            send_sample(prev_level, $urandom);
    endtask

    task automatic send_sync();
        if (prev_level)
            send_sample(1'b0, rise_stamp + pulse_width(1'b0));
        send_sample(1'b1, rise_stamp + {16'd0, gap_limit} + 32'd1 + $urandom_range(0, 2000));
    endtask

    task automatic send_frame(input logic [63:0] bits, input int nbits);
        send_sync();
        for (int k = 0; k < nbits; k++)
        begin
            if (k != 0)
                send_sample(1'b1, rise_stamp + $urandom_range(0, gap_limit));
            maybe_noise();
            send_sample(1'b0, rise_stamp + pulse_width(bits[k]));
            maybe_noise();
        end
    endtask

    task automatic run_free_pulses(input int n);
        for (int k = 0; k < n; k++)
        begin
            if (!prev_level)
                send_sample(1'b1, rise_stamp + $urandom_range(0, gap_limit));
            send_sample(1'b0, rise_stamp + pulse_width(1'($urandom_range(0, 1))));
        end
    endtask

    function automatic logic [63:0] date_frame(input int mn, input int hr, input int dy,
                                               input int mo, input int yr);
        logic [63:0] f;
        logic [7:0]  b;
        f = {$urandom, $urandom};
        b = bcd8(mn);
        f[27:21] = b[6:0];
        b = bcd8(hr);
        f[34:29] = b[5:0];
        b = bcd8(dy);
        f[41:36] = b[5:0];
        b = bcd8(mo);
        f[49:45] = b[4:0];
        f[57:50] = bcd8(yr);
        return f;
    endfunction

    function automatic logic [63:0] random_date_frame();
        return date_frame($urandom_range(0, 59), $urandom_range(0, 23), $urandom_range(1, 31),
                          $urandom_range(1, 12), $urandom_range(0, 99));
    endfunction

    task automatic test_edges_and_thresholds();
        set_idling(0, 0);
        send_sample(1'b1, 32'd5);            // first sample high is a rising edge
        send_sample(1'b1, 32'hFFFF_FFFF);    // unchanged level
        send_sample(1'b0, 32'd144);          // just below split
        send_sample(1'b1, 32'd1205);         // gap equal to sync threshold
        send_sample(1'b0, 32'd1345);         // exactly at split
        send_sample(1'b1, 32'd2406);         // one past sync threshold
        send_sample(1'b0, 32'd0);
        send_sample(1'b0, 32'd0);
        send_sample(1'b1, 32'hFFFF_FF00);
        send_sample(1'b0, 32'h0000_0010);    // width across the wrap
        send_sample(1'b1, 32'h0000_0100);    // gap across the wrap
        send_sample(1'b0, 32'h0000_0100);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'hAAAA_5555);
        send_sample(1'b1, 32'h5555_AAAA);
        drain_block();
    endtask

    task automatic test_clean_frames();
        set_thresholds(SYNC_GAP_RESET, SPLIT_RESET);
        set_idling(0, 0);
        repeat (2) send_frame(random_date_frame(), FRAME_BITS);
        send_sync();
        drain_block();
    endtask

    task automatic test_extreme_thresholds();
        set_idling(67, 0);
        set_thresholds(16'hFFFF, 16'hFFFF);
        send_frame(random_date_frame(), FRAME_BITS);
        send_sync();
        set_thresholds(16'd0, 16'd0);
        send_frame(random_date_frame(), FRAME_BITS);
        send_sync();
        set_thresholds(16'd0, 16'hFFFF);
        send_frame(random_date_frame(), FRAME_BITS);
        send_sync();
        drain_block();
    endtask

    task automatic test_clock_rollover();
        set_thresholds(16'd1100, 16'd150);
        set_idling(0, 67);
        // 23:59 decoded, then free seconds carry into minute and hour wrap
        send_frame(date_frame(59, 23, 31, 12, 99), FRAME_BITS);
        send_sync();
        run_free_pulses(120);
        // junk BCD decoded, counted minutes run on from there
        send_frame({$urandom, $urandom}, FRAME_BITS);
        send_sync();
        run_free_pulses(120);
        drain_block();
    endtask

    task automatic test_broken_frames();
        set_idling(17, 17);
        set_thresholds(16'($urandom_range(300, 3000)), 16'($urandom_range(0, 300)));
        send_frame(random_date_frame(), FRAME_BITS - 1);
        send_frame(random_date_frame(), FRAME_BITS + 2);
        send_frame(random_date_frame(), $urandom_range(0, 61));
        send_sync();
        drain_block();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_request = 300;
        run_free_pulses(20);
        drain_block();
    endtask

    task automatic test_random_samples();
        set_idling(0, 0);
        set_thresholds(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        repeat (150) send_sample(1'($urandom_range(0, 1)), $urandom);
        drain_block();
    endtask

    // receiver side: random stall, or a long counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // output sampled between edges, transfer takes place at the next rising edge
    always @(negedge clk)
    begin
        out_seen = rst_n && out_valid && !out_stall;
        out_snap = {level_echo, seconds, minutes, hours, day_of_month, month_number,
                    year_number, frame_decoded};
    end

    task automatic check_field(input string name, input logic [11:0] exp_v,
                               input logic [11:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (out_seen)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing pending, expected none, actual %h",
                         $time, out_snap);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("level_echo", 12'(want.level_echo), 12'(out_snap.level_echo));
                check_field("seconds", 12'(want.seconds), 12'(out_snap.seconds));
                check_field("minutes", 12'(want.minutes), 12'(out_snap.minutes));
                check_field("hours", 12'(want.hours), 12'(out_snap.hours));
                check_field("day_of_month", 12'(want.day_of_month),
                            12'(out_snap.day_of_month));
                check_field("month_number", 12'(want.month_number),
                            12'(out_snap.month_number));
                check_field("year_number", want.year_number, out_snap.year_number);
                check_field("frame_decoded", 12'(want.frame_decoded),
                            12'(out_snap.frame_decoded));
                results_checked++;
            end
        end
    end

    initial
    begin
        #4800000;
        $display("** dcf77_time_code_receiver: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edges_and_thresholds();
        test_clean_frames();
        test_extreme_thresholds();
        test_clock_rollover();
        test_broken_frames();
        test_backpressure();
        test_random_samples();
        repeat (8) @(posedge clk);
        $display("covered %0d samples, %0d results checked, %0d frames decoded",
                 samples_sent, results_checked, frames_decoded);
        $display("with %0d register writes and %0d stalled input cycles",
                 register_writes, input_stall_cycles);
        if (mismatch_count == 0)
            $display("** dcf77_time_code_receiver: PASSED **");
        else
            $display("** dcf77_time_code_receiver: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== dcf77_time_code_receiver.f =====
sv/dcf_pkg.sv
sv/dcf_frame_decode.sv
sv/dcf77_time_code_receiver.sv
sv/dcf_checker.sv
verif/tb_dcf77_time_code_receiver.sv
